>>> rtl/detector_pixel_descramble_addresser_top_macros.svh
// Assertion macros shared by the descramble addresser RTL.
`ifndef DETECTOR_PIXEL_DESCRAMBLE_ADDRESSER_TOP_MACROS_SVH
`define DETECTOR_PIXEL_DESCRAMBLE_ADDRESSER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DPDA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("descramble addresser assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DPDA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("descramble addresser assertion failed");

`endif

>>> rtl/dpda_pkg.sv
// Package with geometry constants, codes and the step descriptor type.
package dpda_pkg;

  localparam int ROWS_PER_ASIC    = 32;
  localparam int COLS_PER_ASIC    = 16;
  localparam int ASIC_ROWS        = 8;
  localparam int ASIC_COLS        = 16;
  localparam int WORDS_PER_PACKET = 4096;
  localparam int MAX_PACKETS      = 512;
  localparam int QUEUE_DEPTH      = 4;

  localparam int ROW_LEN   = ASIC_COLS * COLS_PER_ASIC;
  localparam int IMG_ROWS  = ASIC_ROWS * ROWS_PER_ASIC;

  localparam int PR_W  = (ROWS_PER_ASIC > 1) ? $clog2(ROWS_PER_ASIC) : 1;
  localparam int PC_W  = (COLS_PER_ASIC > 1) ? $clog2(COLS_PER_ASIC) : 1;
  localparam int AR_W  = (ASIC_ROWS > 1) ? $clog2(ASIC_ROWS) : 1;
  localparam int AC_W  = (ASIC_COLS > 1) ? $clog2(ASIC_COLS) : 1;
  localparam int WD_W  = (WORDS_PER_PACKET > 1) ? $clog2(WORDS_PER_PACKET) : 1;
  localparam int PN_W  = $clog2(MAX_PACKETS + 1);
  localparam int PI_W  = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
  localparam int IR_W  = (IMG_ROWS > 1) ? $clog2(IMG_ROWS) : 1;
  localparam int IC_W  = (ROW_LEN > 1) ? $clog2(ROW_LEN) : 1;

  localparam int KIND_W = 2;
  localparam int IDX_W  = 9;
  localparam int SLOT_W = 16;
  localparam int IMG_W  = 5;
  localparam int IPF_W  = 6;
  localparam int HDR_W  = 16;
  localparam int SRC_W  = 32;
  localparam int DST_W  = 16;

  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_START = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STEP  = 2'd2;

  localparam logic REG_IMAGES = 1'b0;
  localparam logic REG_HEADER = 1'b1;

  localparam logic [SLOT_W-1:0] MISSING_SLOT = 16'hFFFF;
  localparam logic [IPF_W-1:0]  IPF_RESET    = 6'd20;
  localparam logic [IPF_W-1:0]  IPF_MAX      = 6'd32;

  // One pixel move as handed from the front end to the address back end.
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              beyond;
    logic [WD_W-1:0]   word;
    logic [PR_W-1:0]   prow;
    logic [PC_W-1:0]   pcol;
    logic [AR_W-1:0]   arow;
    logic [AC_W-1:0]   acol;
    logic [IMG_W-1:0]  image;
    logic              eoi;
    logic              eof;
  } step_t;

endpackage

>>> rtl/dpda_front.sv
// Front end: takes items, keeps the slot table and the walk counters.
module dpda_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dpda_pkg::KIND_W-1:0]   in_kind,
  input  logic [dpda_pkg::IDX_W-1:0]    in_packet_index,
  input  logic [dpda_pkg::SLOT_W-1:0]   in_slot_value,
  input  logic [dpda_pkg::IPF_W-1:0]    images_per_frame,
  input  logic                          q_full,
  output logic                          q_push,
  output dpda_pkg::step_t               q_data
);

  localparam logic [dpda_pkg::PR_W-1:0] PR_TOP  = dpda_pkg::PR_W'(dpda_pkg::ROWS_PER_ASIC - 1);
  localparam logic [dpda_pkg::PC_W-1:0] PC_LAST = dpda_pkg::PC_W'(dpda_pkg::COLS_PER_ASIC - 1);
  localparam logic [dpda_pkg::AR_W-1:0] AR_TOP  = dpda_pkg::AR_W'(dpda_pkg::ASIC_ROWS - 1);
  localparam logic [dpda_pkg::AC_W-1:0] AC_LAST = dpda_pkg::AC_W'(dpda_pkg::ASIC_COLS - 1);
  localparam logic [dpda_pkg::WD_W-1:0] WD_LAST =
    dpda_pkg::WD_W'(dpda_pkg::WORDS_PER_PACKET - 1);
  localparam logic [dpda_pkg::PN_W-1:0] PN_MAX  = dpda_pkg::PN_W'(dpda_pkg::MAX_PACKETS);

  logic [dpda_pkg::SLOT_W-1:0] slot_mem [dpda_pkg::MAX_PACKETS];

  logic [dpda_pkg::PR_W-1:0]  prow_r, prow_nxt;
  logic [dpda_pkg::PC_W-1:0]  pcol_r, pcol_nxt;
  logic [dpda_pkg::AR_W-1:0]  arow_r, arow_nxt;
  logic [dpda_pkg::AC_W-1:0]  acol_r, acol_nxt;
  logic [dpda_pkg::WD_W-1:0]  word_r, word_nxt;
  logic [dpda_pkg::PN_W-1:0]  pnum_r, pnum_nxt;
  logic [dpda_pkg::IMG_W-1:0] image_r, image_nxt;
  logic                       done_r, done_nxt;
  logic                       hold_vld_r, hold_vld_nxt;
  dpda_pkg::step_t            hold_r;

  logic                       accept;
  logic                       emits;
  logic                       load_ok;
  logic [dpda_pkg::IPF_W-1:0] images;
  logic                       eoi;
  logic                       eof;

  assign in_stall = hold_vld_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign emits    = accept && (in_kind == dpda_pkg::KIND_STEP) && !done_r;
  assign load_ok  = accept && (in_kind == dpda_pkg::KIND_LOAD) &&
                    (32'(in_packet_index) < 32'(dpda_pkg::MAX_PACKETS));
  assign q_push   = hold_vld_r && !q_full;
  assign q_data   = hold_r;

  always_comb begin
    if (images_per_frame == '0) begin
      images = dpda_pkg::IPF_W'(1);
    end else if (images_per_frame > dpda_pkg::IPF_MAX) begin
      images = dpda_pkg::IPF_MAX;
    end else begin
      images = images_per_frame;
    end
  end

  assign eoi = (prow_r == '0) && (pcol_r == PC_LAST) && (arow_r == '0) && (acol_r == AC_LAST);
  assign eof = eoi && ((dpda_pkg::IPF_W'(image_r) + dpda_pkg::IPF_W'(1)) >= images);

  always_comb begin
    prow_nxt     = prow_r;
    pcol_nxt     = pcol_r;
    arow_nxt     = arow_r;
    acol_nxt     = acol_r;
    word_nxt     = word_r;
    pnum_nxt     = pnum_r;
    image_nxt    = image_r;
    done_nxt     = done_r;
    hold_vld_nxt = hold_vld_r;
    if (q_push) begin
      hold_vld_nxt = 1'b0;
    end
    if (accept && (in_kind == dpda_pkg::KIND_START)) begin
      prow_nxt  = PR_TOP;
      pcol_nxt  = '0;
      arow_nxt  = AR_TOP;
      acol_nxt  = '0;
      word_nxt  = '0;
      pnum_nxt  = '0;
      image_nxt = '0;
      done_nxt  = 1'b0;
    end else if (emits) begin
      hold_vld_nxt = 1'b1;
      if (word_r == WD_LAST) begin
        word_nxt = '0;
        if (pnum_r < PN_MAX) begin
          pnum_nxt = pnum_r + dpda_pkg::PN_W'(1);
        end
      end else begin
        word_nxt = word_r + dpda_pkg::WD_W'(1);
      end
      // The pixel counters nest ASIC column, ASIC row, pixel column, pixel row.
      if (eof) begin
        done_nxt = 1'b1;
      end else if (acol_r != AC_LAST) begin
        acol_nxt = acol_r + dpda_pkg::AC_W'(1);
      end else begin
        acol_nxt = '0;
        if (arow_r != '0) begin
          arow_nxt = arow_r - dpda_pkg::AR_W'(1);
        end else begin
          arow_nxt = AR_TOP;
          if (pcol_r != PC_LAST) begin
            pcol_nxt = pcol_r + dpda_pkg::PC_W'(1);
          end else begin
            pcol_nxt = '0;
            if (prow_r != '0) begin
              prow_nxt = prow_r - dpda_pkg::PR_W'(1);
            end else begin
              prow_nxt  = PR_TOP;
              image_nxt = image_r + dpda_pkg::IMG_W'(1);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prow_r     <= PR_TOP;
      pcol_r     <= '0;
      arow_r     <= AR_TOP;
      acol_r     <= '0;
      word_r     <= '0;
      pnum_r     <= '0;
      image_r    <= '0;
      done_r     <= 1'b1;
      hold_vld_r <= 1'b0;
    end else begin
      prow_r     <= prow_nxt;
      pcol_r     <= pcol_nxt;
      arow_r     <= arow_nxt;
      acol_r     <= acol_nxt;
      word_r     <= word_nxt;
      pnum_r     <= pnum_nxt;
      image_r    <= image_nxt;
      done_r     <= done_nxt;
      hold_vld_r <= hold_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      slot_mem[dpda_pkg::PI_W'(in_packet_index)] <= in_slot_value;
    end
  end

  // The slot is read at the edge that takes the step, so loads apply in item order.
  always_ff @(posedge clk) begin
    if (emits) begin
      hold_r.slot   <= slot_mem[pnum_r[dpda_pkg::PI_W-1:0]];
      hold_r.beyond <= (pnum_r >= PN_MAX);
      hold_r.word   <= word_r;
      hold_r.prow   <= prow_r;
      hold_r.pcol   <= pcol_r;
      hold_r.arow   <= arow_r;
      hold_r.acol   <= acol_r;
      hold_r.image  <= image_r;
      hold_r.eoi    <= eoi;
      hold_r.eof    <= eof;
    end
  end

endmodule

>>> rtl/dpda_queue.sv
// Short queue of pixel moves between the front end and the back end.
module dpda_queue #(
  parameter int DEPTH = dpda_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  dpda_pkg::step_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output dpda_pkg::step_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  dpda_pkg::step_t   slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/dpda_back.sv
// Back end: turns pixel moves into source and destination addresses.
module dpda_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  dpda_pkg::step_t              q_head,
  output logic                         q_pop,
  input  logic [dpda_pkg::HDR_W-1:0]   header_words,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [dpda_pkg::SRC_W-1:0]   out_source_address,
  output logic [dpda_pkg::DST_W-1:0]   out_dest_address,
  output logic                         out_zero_fill,
  output logic [dpda_pkg::IMG_W-1:0]   out_image_number,
  output logic                         out_end_of_image,
  output logic                         out_end_of_frame
);

  logic                        a_vld_r, a_vld_nxt;
  logic                        a_fill_r;
  logic [dpda_pkg::SRC_W-1:0]  a_prod_r;
  logic [dpda_pkg::WD_W-1:0]   a_word_r;
  logic [dpda_pkg::IR_W-1:0]   a_row_r;
  logic [dpda_pkg::IC_W-1:0]   a_col_r;
  logic [dpda_pkg::IMG_W-1:0]  a_image_r;
  logic                        a_eoi_r;
  logic                        a_eof_r;
  logic                        out_vld_r, out_vld_nxt;

  logic                        a_en;
  logic                        b_en;
  logic [31:0]                 row_full;
  logic [31:0]                 col_full;
  logic [31:0]                 dest_full;

  assign b_en      = !out_vld_r || !out_stall;
  assign a_en      = !a_vld_r || b_en;
  assign q_pop     = a_en && !q_empty;
  assign a_vld_nxt = a_en ? !q_empty : a_vld_r;
  assign out_vld_nxt = b_en ? a_vld_r : out_vld_r;
  assign out_valid = out_vld_r;

  assign row_full  = 32'(q_head.arow) * 32'(dpda_pkg::ROWS_PER_ASIC) + 32'(q_head.prow);
  assign col_full  = 32'(q_head.acol) * 32'(dpda_pkg::COLS_PER_ASIC) + 32'(q_head.pcol);
  assign dest_full = 32'(a_row_r) * 32'(dpda_pkg::ROW_LEN) + 32'(a_col_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      a_vld_r   <= a_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // First stage: slot times packet length and the image row and column.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_fill_r  <= q_head.beyond || (q_head.slot == dpda_pkg::MISSING_SLOT);
      a_prod_r  <= 32'(q_head.slot) * 32'(dpda_pkg::WORDS_PER_PACKET);
      a_word_r  <= q_head.word;
      a_row_r   <= row_full[dpda_pkg::IR_W-1:0];
      a_col_r   <= col_full[dpda_pkg::IC_W-1:0];
      a_image_r <= q_head.image;
      a_eoi_r   <= q_head.eoi;
      a_eof_r   <= q_head.eof;
    end
  end

  // Second stage: final sums into the output register.
  always_ff @(posedge clk) begin
    if (b_en && a_vld_r) begin
      out_source_address <= a_fill_r ? '0 :
                            32'(header_words) + a_prod_r + 32'(a_word_r);
      out_dest_address   <= dest_full[dpda_pkg::DST_W-1:0];
      out_zero_fill      <= a_fill_r;
      out_image_number   <= a_image_r;
      out_end_of_image   <= a_eoi_r;
      out_end_of_frame   <= a_eof_r;
    end
  end

endmodule

>>> rtl/detector_pixel_descramble_addresser_top.sv
// Top level of the detector pixel descramble address generator.
//
// Input channel (in_valid/in_stall): each transfer carries in_kind with
// in_packet_index and in_slot_value. A load writes one slot table entry, a
// start restarts the pixel walk, a step yields one pixel move. Loads, starts
// and steps outside a walk give no result.
// Result channel (out_valid/out_stall): one transfer per step with the
// source word address, destination pixel address, zero fill, image number
// and end-of-image/end-of-frame flags.
// Throughput is one item per clock while in_stall is low. A step reaches the
// output register through the front register (slot table read at the transfer
// edge), the queue and two address stages (product, then final sums).
// While out_stall is high the back end holds its result and fills the queue;
// the input stalls only once the queue and the front register are full.
// Reset clears the walk state (idle until a start) and sets images_per_frame
// to 20 and header_words to 0; the slot table keeps no reset value and must
// be loaded before it is used.
// Configuration: APB, images_per_frame at byte address 0, header_words at 4.
`include "detector_pixel_descramble_addresser_top_macros.svh"

module detector_pixel_descramble_addresser_top #(
  parameter int QUEUE_DEPTH = dpda_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [dpda_pkg::KIND_W-1:0]  in_kind,
  input  logic [dpda_pkg::IDX_W-1:0]   in_packet_index,
  input  logic [dpda_pkg::SLOT_W-1:0]  in_slot_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [dpda_pkg::SRC_W-1:0]   out_source_address,
  output logic [dpda_pkg::DST_W-1:0]   out_dest_address,
  output logic                         out_zero_fill,
  output logic [dpda_pkg::IMG_W-1:0]   out_image_number,
  output logic                         out_end_of_image,
  output logic                         out_end_of_frame,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  logic [dpda_pkg::IPF_W-1:0] ipf_r, ipf_nxt;
  logic [dpda_pkg::HDR_W-1:0] hdr_r, hdr_nxt;
  logic                       cfg_wr;

  logic                       q_full;
  logic                       q_empty;
  logic                       q_push;
  logic                       q_pop;
  dpda_pkg::step_t            q_in;
  dpda_pkg::step_t            q_head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == dpda_pkg::REG_HEADER) ? 32'(hdr_r) : 32'(ipf_r);

  always_comb begin
    ipf_nxt = ipf_r;
    hdr_nxt = hdr_r;
    if (cfg_wr) begin
      if (paddr[2] == dpda_pkg::REG_IMAGES) begin
        ipf_nxt = pwdata[dpda_pkg::IPF_W-1:0];
      end else begin
        hdr_nxt = pwdata[dpda_pkg::HDR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ipf_r <= dpda_pkg::IPF_RESET;
      hdr_r <= '0;
    end else begin
      ipf_r <= ipf_nxt;
      hdr_r <= hdr_nxt;
    end
  end

  dpda_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_packet_index  (in_packet_index),
    .in_slot_value    (in_slot_value),
    .images_per_frame (ipf_r),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_data           (q_in)
  );

  dpda_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  dpda_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .header_words       (hdr_r),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_source_address (out_source_address),
    .out_dest_address   (out_dest_address),
    .out_zero_fill      (out_zero_fill),
    .out_image_number   (out_image_number),
    .out_end_of_image   (out_end_of_image),
    .out_end_of_frame   (out_end_of_frame)
  );

  `DPDA_ASSERT_SAME(a_eof_has_eoi, out_valid && out_end_of_frame, out_end_of_image)
  `DPDA_ASSERT_SAME(a_fill_src_zero, out_valid && out_zero_fill, out_source_address == '0)
  `DPDA_ASSERT_SAME(a_push_has_room, q_push, !q_full)
  `DPDA_ASSERT_NEXT(a_stall_holds_queue, in_stall && out_stall && out_valid, !q_empty)

endmodule
